FILE: rtl/gfalu_pkg.sv
// gfalu_pkg: shared types, codes and field constants for the gf(2^n) log table alu
// used by the channel interfaces, the table builder and the top level
package gfalu_pkg;

   localparam int MAX_FIELD_BITS_DEFAULT = 16;
   localparam int OPCODE_W = 3;
   localparam int ELEM_W   = 16;
   localparam int MODE_W   = 2;
   localparam int POLY_W   = 17;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_INV = 3'd4
   } opcode_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_GF16    = 2'd0,
      MODE_GF256   = 2'd1,
      MODE_GF65536 = 2'd2
   } field_mode_type;

   typedef enum logic {
      BLD_IDLE = 1'b0,
      BLD_RUN  = 1'b1
   } build_state_type;

   typedef struct packed {
      logic           busy;
      field_mode_type mode;
   } bld_status_type;

   function automatic logic [4:0] mode_bits(input field_mode_type m);
      case (m)
         MODE_GF16:    mode_bits = 5'd4;
         MODE_GF256:   mode_bits = 5'd8;
         MODE_GF65536: mode_bits = 5'd16;
         default:      mode_bits = 5'd4;
      endcase
   endfunction

   function automatic logic [POLY_W-1:0] mode_poly(input field_mode_type m);
      case (m)
         MODE_GF16:    mode_poly = 17'h00013;
         MODE_GF256:   mode_poly = 17'h0011d;
         MODE_GF65536: mode_poly = 17'h1100b;
         default:      mode_poly = 17'h00013;
      endcase
   endfunction

   // all ones of field width, also the multiplicative group order
   function automatic logic [ELEM_W-1:0] mode_mask(input field_mode_type m);
      case (m)
         MODE_GF16:    mode_mask = 16'h000f;
         MODE_GF256:   mode_mask = 16'h00ff;
         MODE_GF65536: mode_mask = 16'hffff;
         default:      mode_mask = 16'h000f;
      endcase
   endfunction

endpackage

FILE: rtl/gfalu_if.sv
// gfalu_if: valid/ready channel interfaces for request, response and csr write
// depends on gfalu_pkg for field widths
interface gfalu_req_if;
   logic                            valid;
   logic                            ready;
   logic [gfalu_pkg::OPCODE_W-1:0]  opcode;
   logic [gfalu_pkg::ELEM_W-1:0]    operand_a;
   logic [gfalu_pkg::ELEM_W-1:0]    operand_b;

   modport source(output valid, opcode, operand_a, operand_b, input ready);
   modport sink(input valid, opcode, operand_a, operand_b, output ready);
endinterface

interface gfalu_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [gfalu_pkg::ELEM_W-1:0]  result;
   logic                          divide_by_zero;

   modport source(output valid, result, divide_by_zero, input ready);
   modport sink(input valid, result, divide_by_zero, output ready);
endinterface

interface gfalu_csr_if;
   logic                          valid;
   logic                          ready;
   logic [gfalu_pkg::MODE_W-1:0]  wdata;

   modport source(output valid, wdata, input ready);
   modport sink(input valid, wdata, output ready);
endinterface

FILE: rtl/gf2n_log_table_alu_top.sv
// gf2n_log_table_alu_top: gf(2^n) add/sub/mul/div/inv unit on log and antilog rams
// depends on gfalu_pkg, gfalu_if, gfalu_ram and gfalu_builder
//
//   channel | dir | payload                           | handshake
//   --------+-----+-----------------------------------+------------------------
//   req_if  | in  | opcode, operand_a, operand_b      | valid & ready
//   rsp_if  | out | result, divide_by_zero            | valid & ready
//   csr_if  | in  | wdata (field_mode)                | valid & ready, ready = 1
//
// one transaction per cycle while rsp_if is ready and no table build runs; a result
// passes the registered reads of the two log rams, then the registered antilog read
// after reset and after each field_mode write that is not dropped the builder writes one
// table entry per cycle, 2^n-1 entries (15, 255 or 65535); req_if.ready is low then
// the whole pipeline advances together; a stalled rsp_if holds every stage,
// including the registered ram read data
// reset is synchronous, active high, and clears control state only
module gf2n_log_table_alu_top #(
   parameter int MAX_FIELD_BITS = gfalu_pkg::MAX_FIELD_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   gfalu_req_if.sink   req_if,
   gfalu_rsp_if.source rsp_if,
   gfalu_csr_if.sink   csr_if
);

   localparam int FW = MAX_FIELD_BITS;

   // per stage payload: either an immediate value or the antilog ram output
   typedef struct packed {
      logic          use_table;
      logic [FW-1:0] imm;
      logic          dz;
   } stage_pay_type;

   gfalu_pkg::bld_status_type bld;
   logic          wr_en;
   logic [FW-1:0] log_wr_addr, log_wr_data, alog_wr_addr, alog_wr_data;

   logic          adv;
   logic          accept;
   logic [FW-1:0] fmask;

   // stage 0 decode
   gfalu_pkg::opcode_type op;
   logic [FW-1:0] a_m, b_m, a_e, b_e;
   logic          is_div;
   stage_pay_type s0_pay;

   // stage 1: log read data valid
   logic          s1_valid_ff, s1_valid_in;
   stage_pay_type s1_pay_ff;
   logic          s1_div_ff;
   logic [FW-1:0] la, lb;
   logic [FW:0]   exp_sum;
   logic [FW-1:0] exp_idx;

   // stage 2: antilog read data valid, output register
   logic          s2_valid_ff, s2_valid_in;
   stage_pay_type s2_pay_ff;
   logic [FW-1:0] alog_rd;

   gfalu_builder #(
      .MAX_FIELD_BITS(MAX_FIELD_BITS)
   ) u_builder (
      .clock        (clock),
      .reset        (reset),
      .csr          (csr_if),
      .status       (bld),
      .wr_en        (wr_en),
      .log_wr_addr  (log_wr_addr),
      .log_wr_data  (log_wr_data),
      .alog_wr_addr (alog_wr_addr),
      .alog_wr_data (alog_wr_data)
   );

   assign fmask  = FW'(gfalu_pkg::mode_mask(bld.mode));
   assign adv    = !s2_valid_ff || rsp_if.ready;
   assign req_if.ready = adv && !bld.busy;
   assign accept = req_if.valid && req_if.ready;

   // operand masking, inverse folded into div with dividend 1
   always_comb begin
      op     = gfalu_pkg::opcode_type'(req_if.opcode);
      a_m    = req_if.operand_a[FW-1:0] & fmask;
      b_m    = req_if.operand_b[FW-1:0] & fmask;
      a_e    = a_m;
      b_e    = b_m;
      is_div = 1'b0;
      s0_pay = '0;
      if (op == gfalu_pkg::OP_INV) begin
         a_e = FW'(1);
         b_e = a_m;
      end
      case (op)
         gfalu_pkg::OP_ADD, gfalu_pkg::OP_SUB: begin
            s0_pay.imm = a_e ^ b_e;
         end
         gfalu_pkg::OP_MUL: begin
            s0_pay.use_table = (a_e != '0) && (b_e != '0);
         end
         gfalu_pkg::OP_DIV, gfalu_pkg::OP_INV: begin
            is_div = 1'b1;
            // zero dividend wins over zero divisor
            if (a_e == '0) begin
               s0_pay.imm = '0;
            end else if (b_e == '0) begin
               s0_pay.imm = fmask;
               s0_pay.dz  = 1'b1;
            end else begin
               s0_pay.use_table = 1'b1;
            end
         end
         default: s0_pay = '0;
      endcase
   end

   // two copies of the log table, one per operand read port
   gfalu_ram #(
      .ADDR_W(FW),
      .DATA_W(FW)
   ) u_log_a (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (log_wr_addr),
      .wr_data (log_wr_data),
      .rd_en   (adv),
      .rd_addr (a_e),
      .rd_data (la)
   );

   gfalu_ram #(
      .ADDR_W(FW),
      .DATA_W(FW)
   ) u_log_b (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (log_wr_addr),
      .wr_data (log_wr_data),
      .rd_en   (adv),
      .rd_addr (b_e),
      .rd_data (lb)
   );

   // exponent modulo the group order 2^n-1, which equals the field mask
   always_comb begin
      if (s1_div_ff) begin
         if (la >= lb) begin
            exp_sum = {1'b0, la} - {1'b0, lb};
         end else begin
            exp_sum = {1'b0, la} + {1'b0, fmask} - {1'b0, lb};
         end
      end else begin
         exp_sum = {1'b0, la} + {1'b0, lb};
         if (exp_sum >= {1'b0, fmask}) begin
            exp_sum = exp_sum - {1'b0, fmask};
         end
      end
      exp_idx = exp_sum[FW-1:0];
   end

   gfalu_ram #(
      .ADDR_W(FW),
      .DATA_W(FW)
   ) u_antilog (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (alog_wr_addr),
      .wr_data (alog_wr_data),
      .rd_en   (adv),
      .rd_addr (exp_idx),
      .rd_data (alog_rd)
   );

   assign s1_valid_in = adv ? accept : s1_valid_ff;
   assign s2_valid_in = adv ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_pay_ff <= s0_pay;
         s1_div_ff <= is_div;
         s2_pay_ff <= s1_pay_ff;
      end
   end

   assign rsp_if.valid          = s2_valid_ff;
   assign rsp_if.result         = s2_pay_ff.use_table ? gfalu_pkg::ELEM_W'(alog_rd)
                                                      : gfalu_pkg::ELEM_W'(s2_pay_ff.imm);
   assign rsp_if.divide_by_zero = s2_pay_ff.dz;

   // no request transaction while the tables are being written
   a_no_accept_in_build: assert property (@(posedge clock) disable iff (reset)
      bld.busy |-> !req_if.ready)
      else $error("request accepted during table build");

   // a stalled result stays in the output stage
   a_result_kept: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !rsp_if.ready) |=> s2_valid_ff)
      else $error("stalled result dropped");

   // divide by zero always returns all ones of the field width
   a_dz_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.divide_by_zero) |-> (rsp_if.result == gfalu_pkg::ELEM_W'(fmask)))
      else $error("divide by zero result is not all ones");

   // a table lookup is only issued for a divide or multiply with a clean flag
   a_table_no_dz: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_pay_ff.use_table) |-> !s1_pay_ff.dz)
      else $error("table lookup carries divide by zero flag");

endmodule

FILE: rtl/gfalu_ram.sv
// gfalu_ram: simple dual port synchronous ram, one write port, one registered read port
// no package dependency
module gfalu_ram #(
   parameter int ADDR_W = 16,
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read data holds while the pipeline is stalled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/gfalu_builder.sv
// gfalu_builder: field mode register and log/antilog table generator
// depends on gfalu_pkg and gfalu_csr_if
module gfalu_builder #(
   parameter int MAX_FIELD_BITS = gfalu_pkg::MAX_FIELD_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   gfalu_csr_if.sink                    csr,
   output gfalu_pkg::bld_status_type    status,
   output logic                         wr_en,
   output logic [MAX_FIELD_BITS-1:0]    log_wr_addr,
   output logic [MAX_FIELD_BITS-1:0]    log_wr_data,
   output logic [MAX_FIELD_BITS-1:0]    alog_wr_addr,
   output logic [MAX_FIELD_BITS-1:0]    alog_wr_data
);

   localparam int VAL_W = MAX_FIELD_BITS + 1;

   gfalu_pkg::build_state_type state_ff, state_in;
   gfalu_pkg::field_mode_type  mode_ff, mode_in;
   logic [MAX_FIELD_BITS-1:0]  count_ff, count_in;
   logic [VAL_W-1:0]           value_ff, value_in;

   gfalu_pkg::field_mode_type  wr_mode;
   logic                       mode_write;
   logic [MAX_FIELD_BITS-1:0]  last_count;
   logic [VAL_W-1:0]           doubled;
   logic [gfalu_pkg::POLY_W-1:0] poly;
   logic [4:0]                 nbits;

   assign csr.ready = 1'b1;

   // modes wider than the tables are dropped, as is the unused code
   always_comb begin
      wr_mode    = gfalu_pkg::field_mode_type'(csr.wdata);
      mode_write = csr.valid && (csr.wdata <= gfalu_pkg::MODE_W'(gfalu_pkg::MODE_GF65536))
                   && (32'(gfalu_pkg::mode_bits(wr_mode)) <= MAX_FIELD_BITS);
   end

   always_comb begin
      nbits      = gfalu_pkg::mode_bits(mode_ff);
      poly       = gfalu_pkg::mode_poly(mode_ff);
      last_count = MAX_FIELD_BITS'(gfalu_pkg::mode_mask(mode_ff)) - MAX_FIELD_BITS'(1);
      doubled    = {value_ff[MAX_FIELD_BITS-1:0], 1'b0};
      if (doubled[nbits]) begin
         doubled = doubled ^ poly[VAL_W-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gfalu_pkg::BLD_IDLE: begin
            if (mode_write) begin
               state_in = gfalu_pkg::BLD_RUN;
            end
         end
         gfalu_pkg::BLD_RUN: begin
            if (mode_write) begin
               state_in = gfalu_pkg::BLD_RUN;
            end else if (count_ff == last_count) begin
               state_in = gfalu_pkg::BLD_IDLE;
            end
         end
         default: state_in = gfalu_pkg::BLD_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      wr_en       = 1'b0;
      status.busy = 1'b0;
      case (state_ff)
         gfalu_pkg::BLD_IDLE: begin
            wr_en       = 1'b0;
            status.busy = 1'b0;
         end
         gfalu_pkg::BLD_RUN: begin
            wr_en       = 1'b1;
            status.busy = 1'b1;
         end
         default: begin
            wr_en       = 1'b0;
            status.busy = 1'b0;
         end
      endcase
      status.mode  = mode_ff;
      log_wr_addr  = value_ff[MAX_FIELD_BITS-1:0];
      log_wr_data  = count_ff;
      alog_wr_addr = count_ff;
      alog_wr_data = value_ff[MAX_FIELD_BITS-1:0];
   end

   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      value_in = value_ff;
      if (mode_write) begin
         mode_in  = wr_mode;
         count_in = '0;
         value_in = VAL_W'(1);
      end else if (state_ff == gfalu_pkg::BLD_RUN) begin
         if (count_ff == last_count) begin
            value_in = VAL_W'(1);
         end else begin
            count_in = count_ff + MAX_FIELD_BITS'(1);
            value_in = doubled;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gfalu_pkg::BLD_RUN;
         mode_ff  <= (MAX_FIELD_BITS >= 8) ? gfalu_pkg::MODE_GF256 : gfalu_pkg::MODE_GF16;
         count_ff <= '0;
         value_ff <= VAL_W'(1);
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         count_ff <= count_in;
         value_ff <= value_in;
      end
   end

endmodule

FILE: tb/gf2n_log_table_alu_checker.sv
`timescale 1ns / 1ps
// gf2n_log_table_alu_checker: watches the request, response and csr channels of the
// gf(2^n) alu, predicts every response from its own log tables and compares them
// depends on gfalu_pkg and gfalu_if
module gf2n_log_table_alu_checker (
   input  logic  clock,
   input  logic  reset,
   gfalu_req_if  req_ch,
   gfalu_rsp_if  rsp_ch,
   gfalu_csr_if  csr_ch,
   output int    fail_count,
   output int    pending_results
);

   typedef struct packed {
      logic [gfalu_pkg::ELEM_W-1:0] result;
      logic                         divide_by_zero;
   } gf_outcome_type;

   gfalu_pkg::field_mode_type    field_mode;
   logic [gfalu_pkg::ELEM_W-1:0] gf_log     [0:(1 << gfalu_pkg::ELEM_W)-1];
   logic [gfalu_pkg::ELEM_W-1:0] gf_antilog [0:(1 << gfalu_pkg::ELEM_W)-1];
   gf_outcome_type               expected_results [$];

   initial begin
      fail_count      = 0;
      pending_results = 0;
      field_mode      = gfalu_pkg::MODE_GF256;
   end

   function automatic int unsigned field_bits(input gfalu_pkg::field_mode_type m);
      case (m)
         gfalu_pkg::MODE_GF16:  return 4;
         gfalu_pkg::MODE_GF256: return 8;
         default:               return 16;
      endcase
   endfunction

   function automatic int unsigned field_poly(input gfalu_pkg::field_mode_type m);
      case (m)
         gfalu_pkg::MODE_GF16:  return 32'h13;
         gfalu_pkg::MODE_GF256: return 32'h11d;
         default:               return 32'h1100b;
      endcase
   endfunction

   // walk the powers of the generator x for the current field
   function automatic void build_field_tables();
      int unsigned card;
      int unsigned poly;
      int unsigned value;
      card  = 32'd1 << field_bits(field_mode);
      poly  = field_poly(field_mode);
      value = 1;
      for (int unsigned k = 0; k < card - 1; k++) begin
         gf_log[value]  = k;
         gf_antilog[k]  = value;
         value = value << 1;
         if ((value & card) != 0)
            value = value ^ poly;
      end
   endfunction

   function automatic gf_outcome_type predict_gf_op(
         input logic [gfalu_pkg::OPCODE_W-1:0] opc,
         input logic [gfalu_pkg::ELEM_W-1:0]   a_in,
         input logic [gfalu_pkg::ELEM_W-1:0]   b_in);
      logic [gfalu_pkg::ELEM_W-1:0] fmask;
      logic [gfalu_pkg::ELEM_W-1:0] a;
      logic [gfalu_pkg::ELEM_W-1:0] b;
      int unsigned                  group_order;
      int unsigned                  la;
      int unsigned                  lb;
      int unsigned                  ex;
      gf_outcome_type               outcome;
      fmask       = (32'd1 << field_bits(field_mode)) - 1;
      group_order = fmask;
      a           = a_in & fmask;
      b           = b_in & fmask;
      outcome     = '0;
      // inverse is 1 / a
      if (opc == gfalu_pkg::OP_INV) begin
         b = a;
         a = 1;
      end
      if (opc == gfalu_pkg::OP_ADD || opc == gfalu_pkg::OP_SUB) begin
         outcome.result = a ^ b;
      end else if (opc == gfalu_pkg::OP_MUL) begin
         if (a != 0 && b != 0) begin
            ex = gf_log[a] + gf_log[b];
            if (ex >= group_order)
               ex = ex - group_order;
            outcome.result = gf_antilog[ex];
         end
      end else if (opc == gfalu_pkg::OP_DIV || opc == gfalu_pkg::OP_INV) begin
         if (a == 0) begin
            outcome.result = '0;
         end else if (b == 0) begin
            outcome.result         = fmask;
            outcome.divide_by_zero = 1'b1;
         end else begin
            la = gf_log[a];
            lb = gf_log[b];
            ex = (la >= lb) ? (la - lb) : (la + group_order - lb);
            outcome.result = gf_antilog[ex];
         end
      end
      return outcome;
   endfunction

   always @(posedge clock) begin
      gf_outcome_type want;
      if (reset) begin
         field_mode = gfalu_pkg::MODE_GF256;
         build_field_tables();
         expected_results.delete();
      end else begin
         // a mode write of 3 is dropped and leaves the tables alone
         if (csr_ch.valid && csr_ch.ready && csr_ch.wdata <= gfalu_pkg::MODE_GF65536) begin
            field_mode = gfalu_pkg::field_mode_type'(csr_ch.wdata);
            build_field_tables();
         end
         if (req_ch.valid && req_ch.ready)
            expected_results.push_back(predict_gf_op(req_ch.opcode, req_ch.operand_a,
                                                     req_ch.operand_b));
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t unexpected response: result %h, divide_by_zero %b", $time,
                        rsp_ch.result, rsp_ch.divide_by_zero);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_ch.result !== want.result) begin
                  $display("%0t result mismatch: expected %h, actual %h", $time,
                           want.result, rsp_ch.result);
                  fail_count++;
               end
               if (rsp_ch.divide_by_zero !== want.divide_by_zero) begin
                  $display("%0t divide_by_zero mismatch: expected %b, actual %b", $time,
                           want.divide_by_zero, rsp_ch.divide_by_zero);
                  fail_count++;
               end
            end
         end
      end
      pending_results = expected_results.size();
   end

endmodule

FILE: tb/gf2n_log_table_alu_top_tb.sv
`timescale 1ns / 1ps
// gf2n_log_table_alu_top_tb: stimulus and verdict for the gf(2^n) log table alu;
// drives bursts of requests and field size writes, the checker does the comparing
// depends on gfalu_pkg, gfalu_if, the alu rtl and gf2n_log_table_alu_checker
module gf2n_log_table_alu_top_tb;

   // opcodes the alu does not define, expected to give 0 with no flag
   localparam logic [gfalu_pkg::OPCODE_W-1:0] OP_UNUSED_FIRST = 3'd5;
   localparam logic [gfalu_pkg::OPCODE_W-1:0] OP_UNUSED_MID   = 3'd6;
   localparam logic [gfalu_pkg::OPCODE_W-1:0] OP_UNUSED_LAST  = 3'd7;
   // field mode code with no field behind it, the write is ignored
   localparam logic [gfalu_pkg::MODE_W-1:0]   MODE_UNUSED     = 2'd3;

   logic        clock;
   logic        reset;
   int          fail_count;
   int          pending_results;

   // receiver stall pattern state
   logic [15:0] ready_pattern;
   int          pattern_age;

   gfalu_req_if req_ch ();
   gfalu_rsp_if rsp_ch ();
   gfalu_csr_if csr_ch ();

   gf2n_log_table_alu_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   gf2n_log_table_alu_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch),
      .csr_ch          (csr_ch),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // everything the tb drives is known from time zero
   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.opcode    = '0;
      req_ch.operand_a = '0;
      req_ch.operand_b = '0;
      rsp_ch.ready     = 1'b0;
      csr_ch.valid     = 1'b0;
      csr_ch.wdata     = '0;
      ready_pattern    = '0;
      pattern_age      = 0;
   end

   // receiver: a 16 bit ready pattern rotated every cycle, reloaded when pattern_age runs out;
   // sometimes always ready, sometimes random, sometimes long stalls
   always @(negedge clock) begin
      if (pattern_age == 0) begin
         case ($urandom_range(0, 3))
            0:       ready_pattern = 16'hffff;
            1:       ready_pattern = $urandom;
            2:       ready_pattern = 16'h0101;
            default: ready_pattern = $urandom | $urandom;
         endcase
         if (ready_pattern == 0)
            ready_pattern = 16'h0001;
         pattern_age = 48;
      end
      rsp_ch.ready  = ready_pattern[0];
      ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
      pattern_age--;
   end

   // one request transaction; called right after a falling edge, returns on one
   task automatic send_op(input logic [gfalu_pkg::OPCODE_W-1:0] opc,
                          input logic [gfalu_pkg::ELEM_W-1:0]   a,
                          input logic [gfalu_pkg::ELEM_W-1:0]   b);
      req_ch.valid     = 1'b1;
      req_ch.opcode    = opc;
      req_ch.operand_a = a;
      req_ch.operand_b = b;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   // operand mix: field extremes, zero in field with high bits set, plain random
   function automatic logic [gfalu_pkg::ELEM_W-1:0] pick_operand();
      logic [gfalu_pkg::ELEM_W-1:0] raw;
      raw = $urandom;
      case ($urandom_range(0, 9))
         0:       return 16'h0000;
         1:       return 16'h0001;
         2:       return 16'h000f;
         3:       return 16'h00ff;
         4:       return 16'hffff;
         5:       return raw & 16'hff00;
         6:       return raw & 16'h00ff;
         7:       return raw & 16'h000f;
         default: return raw;
      endcase
   endfunction

   // random requests in bursts; bursts run back to back or with idle gaps
   task automatic send_random_ops(input int count);
      int                             burst;
      logic [gfalu_pkg::OPCODE_W-1:0] opc;
      while (count > 0) begin
         burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
         for (int k = 0; k < burst && count > 0; k++) begin
            if ($urandom_range(0, 99) < 8)
               opc = $urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST);
            else
               opc = $urandom_range(gfalu_pkg::OP_ADD, gfalu_pkg::OP_INV);
            send_op(opc, pick_operand(), pick_operand());
            count--;
         end
         if ($urandom_range(0, 3) != 0) begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
      end
      req_ch.valid = 1'b0;
   endtask

   // field size write, only once every response is back
   task automatic write_field_mode(input logic [gfalu_pkg::MODE_W-1:0] mode);
      while (pending_results != 0) @(negedge clock);
      csr_ch.valid = 1'b1;
      csr_ch.wdata = mode;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed transactions in the reset field, gf(256)
      send_op(gfalu_pkg::OP_ADD, 16'hffff, 16'hffff);
      send_op(gfalu_pkg::OP_SUB, 16'h00a5, 16'hff5a);
      send_op(gfalu_pkg::OP_ADD, 16'h0000, 16'h0000);
      // zero operand in mul, either side
      send_op(gfalu_pkg::OP_MUL, 16'h0000, 16'h0037);
      send_op(gfalu_pkg::OP_MUL, 16'h0037, 16'h0000);
      send_op(gfalu_pkg::OP_MUL, 16'h0001, 16'h00c3);
      // x times x^7 needs the polynomial reduction
      send_op(gfalu_pkg::OP_MUL, 16'h0002, 16'h0080);
      send_op(gfalu_pkg::OP_MUL, 16'hffff, 16'hffff);
      // high operand bits that leave a zero field element
      send_op(gfalu_pkg::OP_MUL, 16'h0100, 16'h0005);
      // zero dividend wins over a zero divisor
      send_op(gfalu_pkg::OP_DIV, 16'h0000, 16'h0000);
      send_op(gfalu_pkg::OP_DIV, 16'h0000, 16'h0005);
      // zero divisor raises the flag
      send_op(gfalu_pkg::OP_DIV, 16'h0005, 16'h0000);
      send_op(gfalu_pkg::OP_DIV, 16'h00ff, 16'h00ff);
      send_op(gfalu_pkg::OP_DIV, 16'h0001, 16'h0002);
      send_op(gfalu_pkg::OP_DIV, 16'h0002, 16'h00ff);
      // inverse ignores operand b, inverse of zero is a divide by zero
      send_op(gfalu_pkg::OP_INV, 16'h0000, 16'hffff);
      send_op(gfalu_pkg::OP_INV, 16'h0001, 16'h0000);
      send_op(gfalu_pkg::OP_INV, 16'hff8e, 16'h1234);
      // undefined opcodes
      send_op(OP_UNUSED_FIRST, 16'hffff, 16'hffff);
      send_op(OP_UNUSED_MID, 16'h1234, 16'h5678);
      send_op(OP_UNUSED_LAST, 16'h00ff, 16'h0001);
      req_ch.valid = 1'b0;

      send_random_ops(200);

      // walk through every field size, the largest and an ignored code among them
      write_field_mode(gfalu_pkg::MODE_GF16);
      send_random_ops(300);
      write_field_mode(gfalu_pkg::MODE_GF65536);
      send_random_ops(300);
      write_field_mode(MODE_UNUSED);
      send_random_ops(100);
      write_field_mode(gfalu_pkg::MODE_GF256);
      send_random_ops(250);
      write_field_mode(gfalu_pkg::MODE_GF16);
      send_random_ops(200);

      // drain, then let the two stage pipeline settle
      while (pending_results != 0) @(negedge clock);
      repeat (10) @(negedge clock);

      if (pending_results != 0)
         $display("%0t %0d expected results never arrived", $time, pending_results);
      if (fail_count == 0 && pending_results == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // watchdog: real runs need well under a quarter of this
   initial begin
      #5000000;
      $display("FAIL");
      $finish;
   end

endmodule
